// ----- rtl/core/pva_pkg.sv -----
// pva_pkg: shared types, constants and the note frequency table
// for the polyphonic voice allocator; no dependencies
package pva_pkg;

	typedef enum logic [1:0] {
		REQ_NOTE_ON  = 2'd0,
		REQ_NOTE_OFF = 2'd1,
		REQ_REPORT   = 2'd2,
		REQ_UNUSED   = 2'd3
	} req_t;

	localparam logic [1:0] CFG_LEGATO    = 2'd0;
	localparam logic [1:0] CFG_THRESHOLD = 2'd1;
	localparam logic [1:0] CFG_HOLD      = 2'd2;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [6:0]  note_number;
		logic [15:0] velocity;
		logic [3:0]  voice_id;
		logic [15:0] peak_level;
	} in_item_t;

	typedef struct packed {
		logic        status;
		logic [3:0]  voice_out;
		logic        setup_valid;
		logic        gate;
		logic [21:0] pitch_q8;
		logic [15:0] attack;
		logic        init_state;
		logic        stopped;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SWAP1,
		ST_SWAP2,
		ST_DONE
	} state_t;

	// note frequency in Q14.8 Hz, rounded from millihertz
	function automatic logic [21:0] note_pitch(input logic [6:0] n);
		logic [31:0] mhz;
		logic [28:0] y;
		logic [57:0] prod;
		begin
			unique case (n)
			7'd0: mhz = 32'd8176; 7'd1: mhz = 32'd8662; 7'd2: mhz = 32'd9177;
			7'd3: mhz = 32'd9723; 7'd4: mhz = 32'd10301; 7'd5: mhz = 32'd10913;
			7'd6: mhz = 32'd11562; 7'd7: mhz = 32'd12250; 7'd8: mhz = 32'd12978;
			7'd9: mhz = 32'd13750; 7'd10: mhz = 32'd14568; 7'd11: mhz = 32'd15434;
			7'd12: mhz = 32'd16352; 7'd13: mhz = 32'd17324; 7'd14: mhz = 32'd18354;
			7'd15: mhz = 32'd19445; 7'd16: mhz = 32'd20602; 7'd17: mhz = 32'd21827;
			7'd18: mhz = 32'd23125; 7'd19: mhz = 32'd24500; 7'd20: mhz = 32'd25957;
			7'd21: mhz = 32'd27500; 7'd22: mhz = 32'd29135; 7'd23: mhz = 32'd30868;
			7'd24: mhz = 32'd32703; 7'd25: mhz = 32'd34648; 7'd26: mhz = 32'd36708;
			7'd27: mhz = 32'd38891; 7'd28: mhz = 32'd41203; 7'd29: mhz = 32'd43654;
			7'd30: mhz = 32'd46249; 7'd31: mhz = 32'd48999; 7'd32: mhz = 32'd51913;
			7'd33: mhz = 32'd55000; 7'd34: mhz = 32'd58270; 7'd35: mhz = 32'd61735;
			7'd36: mhz = 32'd65406; 7'd37: mhz = 32'd69296; 7'd38: mhz = 32'd73416;
			7'd39: mhz = 32'd77782; 7'd40: mhz = 32'd82407; 7'd41: mhz = 32'd87307;
			7'd42: mhz = 32'd92499; 7'd43: mhz = 32'd97999; 7'd44: mhz = 32'd103826;
			7'd45: mhz = 32'd110000; 7'd46: mhz = 32'd116541; 7'd47: mhz = 32'd123471;
			7'd48: mhz = 32'd130813; 7'd49: mhz = 32'd138591; 7'd50: mhz = 32'd146832;
			7'd51: mhz = 32'd155563; 7'd52: mhz = 32'd164814; 7'd53: mhz = 32'd174614;
			7'd54: mhz = 32'd184997; 7'd55: mhz = 32'd195998; 7'd56: mhz = 32'd207652;
			7'd57: mhz = 32'd220000; 7'd58: mhz = 32'd233082; 7'd59: mhz = 32'd246942;
			7'd60: mhz = 32'd261626; 7'd61: mhz = 32'd277183; 7'd62: mhz = 32'd293665;
			7'd63: mhz = 32'd311127; 7'd64: mhz = 32'd329628; 7'd65: mhz = 32'd349228;
			7'd66: mhz = 32'd369994; 7'd67: mhz = 32'd391995; 7'd68: mhz = 32'd415305;
			7'd69: mhz = 32'd440000; 7'd70: mhz = 32'd466164; 7'd71: mhz = 32'd493883;
			7'd72: mhz = 32'd523251; 7'd73: mhz = 32'd554365; 7'd74: mhz = 32'd587330;
			7'd75: mhz = 32'd622254; 7'd76: mhz = 32'd659255; 7'd77: mhz = 32'd698456;
			7'd78: mhz = 32'd739989; 7'd79: mhz = 32'd783991; 7'd80: mhz = 32'd830609;
			7'd81: mhz = 32'd880000; 7'd82: mhz = 32'd932328; 7'd83: mhz = 32'd987767;
			7'd84: mhz = 32'd1046502; 7'd85: mhz = 32'd1108731; 7'd86: mhz = 32'd1174659;
			7'd87: mhz = 32'd1244508; 7'd88: mhz = 32'd1318510; 7'd89: mhz = 32'd1396913;
			7'd90: mhz = 32'd1479978; 7'd91: mhz = 32'd1567982; 7'd92: mhz = 32'd1661219;
			7'd93: mhz = 32'd1760000; 7'd94: mhz = 32'd1864655; 7'd95: mhz = 32'd1975533;
			7'd96: mhz = 32'd2093005; 7'd97: mhz = 32'd2217461; 7'd98: mhz = 32'd2349318;
			7'd99: mhz = 32'd2489016; 7'd100: mhz = 32'd2637020; 7'd101: mhz = 32'd2793826;
			7'd102: mhz = 32'd2959955; 7'd103: mhz = 32'd3135963; 7'd104: mhz = 32'd3322438;
			7'd105: mhz = 32'd3520000; 7'd106: mhz = 32'd3729310; 7'd107: mhz = 32'd3951066;
			7'd108: mhz = 32'd4186009; 7'd109: mhz = 32'd4434922; 7'd110: mhz = 32'd4698636;
			7'd111: mhz = 32'd4978032; 7'd112: mhz = 32'd5274041; 7'd113: mhz = 32'd5587652;
			7'd114: mhz = 32'd5919911; 7'd115: mhz = 32'd6271927; 7'd116: mhz = 32'd6644875;
			7'd117: mhz = 32'd7040000; 7'd118: mhz = 32'd7458620; 7'd119: mhz = 32'd7902133;
			7'd120: mhz = 32'd8372018; 7'd121: mhz = 32'd8869844; 7'd122: mhz = 32'd9397273;
			7'd123: mhz = 32'd9956063; 7'd124: mhz = 32'd10548080; 7'd125: mhz = 32'd11175300;
			7'd126: mhz = 32'd11839820; default: mhz = 32'd12543850;
			endcase
			// (mhz*256 + 500) / 1000 == (mhz*32 + 62) / 125, the latter by
			// reciprocal multiplication, exact over the whole table
			y = {mhz[23:0], 5'd0} + 29'd62;
			prod = {29'd0, y} * {29'd0, 29'd274877907};
			note_pitch = prod[56:35];
		end
	endfunction

endpackage

// ----- rtl/core/pva_slot_scan.sv -----
// pva_slot_scan: shared compare unit that walks the slot table one entry a cycle
// depends on pva_pkg
module pva_slot_scan import pva_pkg::*; #(
	parameter int IW = 4,
	parameter int CW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [CW-1:0] limit,
	input  logic [6:0]    key,
	input  logic          by_voice,
	input  logic [IW-1:0] cur_voice,
	input  logic [6:0]    cur_note,
	output logic [IW-1:0] idx,
	output logic          busy,
	output logic          hit,
	output logic          miss
);
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          match;

	assign idx  = cnt_q[IW-1:0];
	assign busy = run_q;
	assign match = by_voice ? (key == 7'(cur_voice)) : (key == cur_note);
	assign hit  = run_q && (cnt_q < limit) && match;
	assign miss = run_q && (cnt_q >= limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			run_q <= 1'b0;
		end else if (start) begin
			cnt_q <= '0;
			run_q <= 1'b1;
		end else if (hit || miss) begin
			run_q <= 1'b0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end
endmodule

// ----- rtl/core/poly_voice_allocator.sv -----
// Polyphonic voice allocator. One item is handled at a time by a small
// sequencer. A note-on or an unknown request goes straight from the scan
// state to the done state. A note-off or level report walks the slot table
// one slot a cycle through one shared compare unit (kicked in the cycle
// after acceptance) and, on a match, passes through two slot-swap states
// before its result is ready. The result is held in an output register
// until taken; the next item is accepted the cycle after that.
// depends on pva_pkg, pva_slot_scan
module poly_voice_allocator import pva_pkg::*; #(
	parameter int VOICES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int CW = $clog2(VOICES + 1);

	state_t state_q, state_d;
	logic [IW-1:0] slot_voice_q [VOICES];
	logic [6:0]    slot_note_q [VOICES];
	logic [15:0]   silence_q [VOICES];
	logic [CW-1:0] held_q, active_q;
	logic          legato_q;
	logic [15:0]   thr_q, hold_q;
	in_item_t      req_q;
	out_item_t     res_q;
	logic          ov_q;
	logic [IW-1:0] p_q;
	logic          held_hit_q;
	logic          free_q;

	logic          acc, start, sbusy, shit, smiss;
	logic [IW-1:0] sidx;
	logic          by_voice;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE) && !ov_q;
	assign acc       = in_valid && in_ready;
	assign out_valid = ov_q;
	assign out_data  = res_q;
	assign by_voice  = (req_q.req_type == REQ_REPORT);

	pva_slot_scan #(.IW(IW), .CW(CW)) u_scan (
		.clk(clk), .arst_n(arst_n), .start(start),
		.limit(by_voice ? active_q : held_q),
		.key(by_voice ? 7'(req_q.voice_id) : req_q.note_number),
		.by_voice(by_voice),
		.cur_voice(slot_voice_q[sidx]), .cur_note(slot_note_q[sidx]),
		.idx(sidx), .busy(sbusy), .hit(shit), .miss(smiss)
	);

	logic vid_ok;
	assign vid_ok = (32'(req_q.voice_id) < VOICES);
	logic is_scan;
	assign is_scan = (req_q.req_type == REQ_NOTE_OFF) || (req_q.req_type == REQ_REPORT);

	logic scan_go_q;
	// the scanner is kicked in the cycle after acceptance
	assign start = scan_go_q && is_scan && !sbusy;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
		ST_IDLE:  if (acc) state_d = ST_SCAN;
		ST_SCAN:  begin
			if (!is_scan) state_d = ST_DONE;
			else if (shit) state_d = ST_SWAP1;
			else if (smiss) state_d = ST_DONE;
		end
		ST_SWAP1: state_d = ST_SWAP2;
		ST_SWAP2: state_d = ST_DONE;
		ST_DONE:  state_d = ST_IDLE;
		default:  state_d = ST_IDLE;
		endcase
	end

	logic [15:0] dec;
	assign dec = silence_q[slot_voice_q[sidx]] - 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ov_q     <= 1'b0;
			held_q   <= '0;
			active_q <= '0;
			legato_q <= 1'b0;
			thr_q    <= 16'd1;
			hold_q   <= 16'd4800;
			scan_go_q <= 1'b0;
			req_q    <= '0;
			res_q    <= '0;
			p_q      <= '0;
			held_hit_q <= 1'b0;
			free_q   <= 1'b0;
			for (int i = 0; i < VOICES; i++) begin
				slot_voice_q[i] <= IW'(i);
				slot_note_q[i]  <= '0;
				silence_q[i]    <= '0;
			end
		end else begin
			state_q <= state_d;
			scan_go_q <= acc;
			if (cfg_valid) begin
				unique case (cfg_index)
				CFG_LEGATO:    legato_q <= cfg_data[0];
				CFG_THRESHOLD: thr_q <= cfg_data;
				CFG_HOLD:      hold_q <= cfg_data;
				default:       ;
				endcase
			end
			if (ov_q && out_ready) ov_q <= 1'b0;
			if (acc) begin
				req_q <= in_data;
				res_q <= out_item_t'({1'b1, 46'd0});
				free_q <= 1'b0;
			end
			if (state_q == ST_SCAN && !is_scan) begin
				if (req_q.req_type == REQ_NOTE_ON) begin
					if (legato_q && held_q != '0) begin
						slot_note_q[IW'(held_q - 1'b1)] <= req_q.note_number;
						silence_q[slot_voice_q[IW'(held_q - 1'b1)]] <= hold_q;
						res_q <= '{1'b0, 4'(slot_voice_q[IW'(held_q - 1'b1)]), 1'b1, 1'b1,
							note_pitch(req_q.note_number), req_q.velocity, 1'b0, 1'b0};
					end else if (32'(active_q) < VOICES) begin
						silence_q[slot_voice_q[IW'(active_q)]] <= hold_q;
						res_q <= '{1'b0, 4'(slot_voice_q[IW'(active_q)]), 1'b1, 1'b1,
							note_pitch(req_q.note_number), req_q.velocity, 1'b1, 1'b0};
						// swap free slot into held region, then set its note
						slot_voice_q[IW'(held_q)] <= slot_voice_q[IW'(active_q)];
						slot_voice_q[IW'(active_q)] <= slot_voice_q[IW'(held_q)];
						slot_note_q[IW'(active_q)] <= slot_note_q[IW'(held_q)];
						slot_note_q[IW'(held_q)] <= req_q.note_number;
						active_q <= active_q + 1'b1;
						held_q <= held_q + 1'b1;
					end
				end
			end
			if (state_q == ST_SCAN && is_scan && shit) begin
				p_q <= sidx;
				held_hit_q <= (CW'(sidx) < held_q);
				if (req_q.req_type == REQ_NOTE_OFF) begin
					res_q.status <= 1'b0;
					res_q.voice_out <= 4'(slot_voice_q[sidx]);
					free_q <= 1'b0;
				end else begin
					res_q.voice_out <= req_q.voice_id;
					res_q.status <= !vid_ok;
					if (req_q.peak_level <= thr_q) begin
						silence_q[slot_voice_q[sidx]] <= dec;
						free_q <= (dec == 16'd0);
					end else begin
						silence_q[slot_voice_q[sidx]] <= hold_q;
						free_q <= 1'b0;
					end
				end
			end
			if (state_q == ST_SCAN && is_scan && smiss && req_q.req_type == REQ_REPORT)
				res_q.voice_out <= req_q.voice_id;
			// first swap: leave the held region
			if (state_q == ST_SWAP1) begin
				if (held_hit_q && (req_q.req_type == REQ_NOTE_OFF || free_q)) begin
					slot_voice_q[p_q] <= slot_voice_q[IW'(held_q - 1'b1)];
					slot_voice_q[IW'(held_q - 1'b1)] <= slot_voice_q[p_q];
					slot_note_q[p_q] <= slot_note_q[IW'(held_q - 1'b1)];
					slot_note_q[IW'(held_q - 1'b1)] <= slot_note_q[p_q];
					held_q <= held_q - 1'b1;
					p_q <= IW'(held_q - 1'b1);
				end
			end
			// second swap: leave the active region
			if (state_q == ST_SWAP2 && free_q) begin
				slot_voice_q[p_q] <= slot_voice_q[IW'(active_q - 1'b1)];
				slot_voice_q[IW'(active_q - 1'b1)] <= slot_voice_q[p_q];
				slot_note_q[p_q] <= slot_note_q[IW'(active_q - 1'b1)];
				slot_note_q[IW'(active_q - 1'b1)] <= slot_note_q[p_q];
				active_q <= active_q - 1'b1;
				res_q.stopped <= 1'b1;
			end
			if (state_q == ST_DONE) ov_q <= 1'b1;
		end
	end
endmodule

// pva_checker: handshake properties seen on the allocator's ports
module pva_checker import pva_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);
	// a waiting result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data));
	// one item at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready);
	a_no_accept_while_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready);
endmodule

bind poly_voice_allocator pva_checker u_pva_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
